>>> rtl/att_pkg.sv
// Shared types, constants and the arctangent table for the tilt-angle pipeline.
package att_pkg;

    localparam int AXIS_W = 10;
    localparam int SQ_W   = 20;     // a^2 + b^2, at most 2*512^2
    localparam int RAD_W  = 18;     // sqrt(sq * 2^16) < 2^18
    localparam int CV_W   = 22;     // CORDIC x and y datapath
    localparam int ANG_W  = 17;     // angle/pi, Q1.15 plus guard bit
    localparam int SCL_W  = 10;
    localparam int OUT_W  = 10;
    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [ANG_W-1:0] HALF_PI = 17'sd16384;

    typedef enum logic [0:0] {
        CFG_PITCH_SCALE = 1'b0,
        CFG_ROLL_SCALE  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic zero_num;   // numerator is zero: angle 0
        logic zero_den;   // denominator is zero: angle +-pi/2
        logic neg_num;
    } t_tilt_flags;

    function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            5'd0:  v = 17'sd8192;
            5'd1:  v = 17'sd4836;
            5'd2:  v = 17'sd2555;
            5'd3:  v = 17'sd1297;
            5'd4:  v = 17'sd651;
            5'd5:  v = 17'sd326;
            5'd6:  v = 17'sd163;
            5'd7:  v = 17'sd81;
            5'd8:  v = 17'sd41;
            5'd9:  v = 17'sd20;
            5'd10: v = 17'sd10;
            5'd11: v = 17'sd5;
            5'd12: v = 17'sd3;
            5'd13: v = 17'sd1;
            5'd14: v = 17'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/att_if.sv
// Valid/ready channel carrying a packed payload.
interface att_if #(parameter int W = 8) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/att_isqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per step.
module att_isqrt
    import att_pkg::*;
#(
    parameter int IN_W  = 36,
    parameter int OUT_W = 18
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [IN_W-1:0]  i_val,
    output logic [OUT_W-1:0] o_root
);
    localparam int STEPS = OUT_W;
    localparam int RW    = IN_W + 2;

    logic [RW-1:0] r_rem [STEPS+1];
    logic [RW-1:0] r_res [STEPS+1];

    always_comb begin
        r_rem[0] = RW'(i_val);
        r_res[0] = '0;
    end

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        localparam int BITPOS = 2 * (STEPS - 1 - s);
        logic [RW-1:0] bitv, n_rem, n_res;
        always_comb begin
            bitv = RW'(1) << BITPOS;
            if (r_rem[s] >= r_res[s] + bitv) begin
                n_rem = r_rem[s] - (r_res[s] + bitv);
                n_res = (r_res[s] >> 1) + bitv;
            end else begin
                n_rem = r_rem[s];
                n_res = r_res[s] >> 1;
            end
        end
        // two stages share one register level to keep the depth modest
        if (s % 2 == 1) begin : g_reg
            logic [RW-1:0] r_a, r_b;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a <= n_rem;
                    r_b <= n_res;
                end
            end
            assign r_rem[s+1] = r_a;
            assign r_res[s+1] = r_b;
        end else begin : g_comb
            assign r_rem[s+1] = n_rem;
            assign r_res[s+1] = n_res;
        end
    end

    assign o_root = r_res[STEPS][OUT_W-1:0];
endmodule

>>> rtl/att_cordic.sv
// Pipelined vectoring CORDIC: angle/pi of atan2(y, x) in Q1.15, clamped.
module att_cordic
    import att_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [RAD_W-1:0]        i_x,
    input  logic signed [AXIS_W-1:0] i_num,
    input  t_tilt_flags             i_flags,
    output logic signed [ANG_W-1:0] o_angle
);
    localparam int N = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    logic signed [CV_W-1:0]   r_x [N+1];
    logic signed [CV_W-1:0]   r_y [N+1];
    logic signed [ANG_W+1:0]  r_z [N+1];
    t_tilt_flags              r_f [N+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CV_W'(signed'({1'b0, i_x}));
            r_y[0] <= CV_W'(i_num) <<< 8;
            r_z[0] <= '0;
            r_f[0] <= i_flags;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [CV_W-1:0] xs, ys;
        logic signed [ANG_W-1:0] a;
        always_comb begin
            xs = r_x[i] >>> i;
            ys = r_y[i] >>> i;
            a  = atan_lut(5'(i));
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y[i][CV_W-1]) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + (ANG_W+2)'(a);
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - (ANG_W+2)'(a);
                end
                r_f[i+1] <= r_f[i];
            end
        end
    end

    always_comb begin
        priority if (r_f[N].zero_num)
            o_angle = '0;
        else if (r_f[N].zero_den)
            o_angle = r_f[N].neg_num ? -HALF_PI : HALF_PI;
        else if (r_z[N] > (ANG_W+2)'(HALF_PI))
            o_angle = HALF_PI;
        else if (r_z[N] < -(ANG_W+2)'(HALF_PI))
            o_angle = -HALF_PI;
        else
            o_angle = r_z[N][ANG_W-1:0];
    end
endmodule

>>> rtl/accelerometer_tilt_angles.sv
// Accelerometer pitch/roll: squares, pipelined sqrt, CORDIC and output scaling.
// The sqrt has two result bits per register level; one item per cycle is
// sustained while the output is not stalled.
// The whole pipeline advances together; a stalled output freezes it, and the
// output register still lets a new item in while its slot is free.
// Reset clears valid bits and sets the scales to 128 (pitch) and 160 (roll).
module accelerometer_tilt_angles
    import att_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    att_if.sink           s_in,
    att_if.source         m_out,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_idx,
    input  logic [SCL_W-1:0] i_cfg_data
);
    localparam int NC  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int SQL = RAD_W / 2;          // isqrt register levels
    // axes, squares, sqrt, CORDIC input, CORDIC stages, product, output
    localparam int LAT = 2 + SQL + 1 + NC + 1 + 1;

    logic [SCL_W-1:0] r_pscale, r_rscale;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pscale <= SCL_W'(128);
            r_rscale <= SCL_W'(160);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PITCH_SCALE: r_pscale <= i_cfg_data;
                CFG_ROLL_SCALE:  r_rscale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic [LAT-1:0] r_vld;
    assign en = !r_vld[LAT-1] || m_out.ready;
    assign s_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= '0;
        else if (en)
            r_vld <= {r_vld[LAT-2:0], s_in.valid};
    end

    // stage 1: axes
    logic [7:0] xh, yh, zh, lb;
    assign {xh, yh, zh, lb} = s_in.data;
    logic signed [AXIS_W-1:0] r_ax, r_ay, r_az;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax <= signed'({xh, lb[3:2]} ^ 10'h200);
            r_ay <= signed'({yh, lb[5:4]} ^ 10'h200);
            r_az <= signed'({zh, lb[7:6]} ^ 10'h200);
        end
    end

    // stage 2: sums of squares
    logic [SQ_W-1:0] r_sqp, r_sqr;
    logic signed [AXIS_W-1:0] r2_x, r2_y;
    logic r2_all0;
    logic [SQ_W-1:0] x2, y2, z2;
    assign x2 = SQ_W'(r_ax * r_ax);
    assign y2 = SQ_W'(r_ay * r_ay);
    assign z2 = SQ_W'(r_az * r_az);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqp <= y2 + z2;
            r_sqr <= x2 + z2;
            r2_x <= r_ax;
            r2_y <= r_ay;
            r2_all0 <= (r_ax == '0) && (r_ay == '0) && (r_az == '0);
        end
    end

    logic [RAD_W-1:0] rad_p, rad_r;
    att_isqrt #(.IN_W(SQ_W + 16), .OUT_W(RAD_W)) u_sqp (
        .i_clk(i_clk), .i_en(en), .i_val({r_sqp, 16'h0}), .o_root(rad_p));
    att_isqrt #(.IN_W(SQ_W + 16), .OUT_W(RAD_W)) u_sqr (
        .i_clk(i_clk), .i_en(en), .i_val({r_sqr, 16'h0}), .o_root(rad_r));

    // delay numerators alongside the square root
    logic signed [AXIS_W-1:0] r_dx [SQL+1];
    logic signed [AXIS_W-1:0] r_dy [SQL+1];
    logic r_d0 [SQL+1];
    always_comb begin
        r_dx[0] = r2_x;
        r_dy[0] = r2_y;
        r_d0[0] = r2_all0;
    end
    for (genvar k = 0; k < SQL; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dx[k+1] <= r_dx[k];
                r_dy[k+1] <= r_dy[k];
                r_d0[k+1] <= r_d0[k];
            end
        end
    end

    t_tilt_flags fp, fr;
    always_comb begin
        fp.zero_num = (r_dx[SQL] == '0) || r_d0[SQL];
        fp.zero_den = (rad_p == '0);
        fp.neg_num  = r_dx[SQL][AXIS_W-1];
        fr.zero_num = (r_dy[SQL] == '0) || r_d0[SQL];
        fr.zero_den = (rad_r == '0);
        fr.neg_num  = r_dy[SQL][AXIS_W-1];
    end

    logic signed [ANG_W-1:0] ang_p, ang_r;
    att_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cp (
        .i_clk(i_clk), .i_en(en), .i_x(rad_p), .i_num(r_dx[SQL]),
        .i_flags(fp), .o_angle(ang_p));
    att_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cr (
        .i_clk(i_clk), .i_en(en), .i_x(rad_r), .i_num(r_dy[SQL]),
        .i_flags(fr), .o_angle(ang_r));

    // scale multiply, then truncate toward zero and register the result
    logic signed [ANG_W+SCL_W:0] r_pp, r_pr;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pp <= ang_p * signed'({1'b0, r_pscale});
            r_pr <= ang_r * signed'({1'b0, r_rscale});
        end
    end

    function automatic logic [OUT_W-1:0] trunc_q15(input logic signed [ANG_W+SCL_W:0] p);
        logic signed [ANG_W+SCL_W:0] adj, q;
        adj = p + (p[ANG_W+SCL_W] ? (ANG_W+SCL_W+1)'(32767) : '0);
        q = adj >>> 15;
        return q[OUT_W-1:0];
    endfunction

    logic [OUT_W-1:0] r_po, r_ro;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_po <= trunc_q15(r_pp);
            r_ro <= trunc_q15(r_pr);
        end
    end

    assign m_out.valid = r_vld[LAT-1];
    assign m_out.data  = {r_po, r_ro};

    // a stalled result must hold
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.data))
        else $error("result changed under stall");
    // no input is taken while the output is blocked
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |-> !s_in.ready)
        else $error("input accepted while pipeline frozen");
    // output magnitude never exceeds 511 for pitch
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> m_out.data[2*OUT_W-1:OUT_W] != 10'h200)
        else $error("pitch out of range");
endmodule

>>> sim/tb_accelerometer_tilt_angles.sv
// Self-checking testbench for the accelerometer tilt-angle pipeline.
module tb_accelerometer_tilt_angles;
    import att_pkg::*;

    localparam int IN_W  = 32;
    localparam int RES_W = 2 * OUT_W;
    localparam int STAGES = 16;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic signed [OUT_W-1:0] pitch;
        logic signed [OUT_W-1:0] roll;
    } t_angles;

    typedef struct {
        logic [7:0] xh, yh, zh, lo;
        bit         typed;
        int         pitch, roll;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [0:0] i_cfg_idx = '0;
    logic [SCL_W-1:0] i_cfg_data = '0;

    att_if #(.W(IN_W))  rpt_if ();
    att_if #(.W(RES_W)) ang_if ();

    accelerometer_tilt_angles #(.CORDIC_STAGES(STAGES)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_in(rpt_if.sink), .m_out(ang_if.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        rpt_if.valid = 1'b0;
        rpt_if.data  = '0;
        ang_if.ready = 1'b0;
    end

    int unsigned pitch_scl = 128;
    int unsigned roll_scl  = 160;
    t_angles     angles_due[$];
    int          errors = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 40;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic int atan_step(input int i);
        int tab [24] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5,
                         3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        return tab[i];
    endfunction

    // angle/pi in Q1.15 of atan2(num, sqrt(a^2 + b^2))
    function automatic int tilt_q15(input int num, input int a, input int b);
        longint x, y, xs, ys;
        int z;
        z = 0;
        x = longint'(int_sqrt(longint'(a * a + b * b) * 65536));
        y = longint'(num) * 256;
        if (num == 0) return 0;
        if (x == 0) return (num > 0) ? 16384 : -16384;
        for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_step(i);
            end else begin
                x -= ys; y += xs; z -= atan_step(i);
            end
        end
        if (z > 16384) z = 16384;
        if (z < -16384) z = -16384;
        return z;
    endfunction

    function automatic logic signed [OUT_W-1:0] scaled(input int ang, input int unsigned s);
        longint p;
        p = (longint'(ang) * longint'(s & 10'h3FF)) / 32768;
        if (p > 511) p = 511;
        if (p < -512) p = -512;
        return p[OUT_W-1:0];
    endfunction

    function automatic t_angles tilt_angles(input logic [7:0] xh, yh, zh, lo);
        t_angles r;
        int ax, ay, az, p, q;
        ax = int'(xh) * 4 + int'(lo[3:2]) - 512;
        ay = int'(yh) * 4 + int'(lo[5:4]) - 512;
        az = int'(zh) * 4 + int'(lo[7:6]) - 512;
        p = 0;
        q = 0;
        if (ax != 0 || ay != 0 || az != 0) begin
            p = tilt_q15(ax, ay, az);
            q = tilt_q15(ay, ax, az);
        end
        r.pitch = scaled(p, pitch_scl);
        r.roll  = scaled(q, roll_scl);
        return r;
    endfunction

    task automatic send_report(input t_row row);
        t_angles e;
        rpt_if.valid <= 1'b1;
        rpt_if.data  <= {row.xh, row.yh, row.zh, row.lo};
        do @(posedge i_clk); while (!rpt_if.ready);
        e = tilt_angles(row.xh, row.yh, row.zh, row.lo);
        if (row.typed) begin
            e.pitch = row.pitch[OUT_W-1:0];
            e.roll  = row.roll[OUT_W-1:0];
        end
        angles_due.push_back(e);
    endtask

    task automatic sender_gap();
        int n;
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (n > 0) begin
            rpt_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        rpt_if.valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_scale(input t_cfg_idx idx, input int unsigned v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v[SCL_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_PITCH_SCALE) pitch_scl = v;
        else roll_scl = v;
    endtask

    function automatic t_row rand_row();
        t_row r;
        r.typed = 1'b0;
        r.lo = 8'($urandom);
        case ($urandom_range(0, 3))
            0: begin   // near level: tiny axes, zero and zero-denominator cases
                r.xh = 8'($urandom_range(127, 129));
                r.yh = 8'($urandom_range(127, 129));
                r.zh = 8'($urandom_range(127, 129));
            end
            1: begin   // one axis dominant
                r.xh = ($urandom_range(0, 1)) ? 8'd255 : 8'd0;
                r.yh = 8'($urandom_range(120, 136));
                r.zh = 8'($urandom_range(120, 136));
            end
            default: begin
                r.xh = 8'($urandom);
                r.yh = 8'($urandom);
                r.zh = 8'($urandom);
            end
        endcase
        return r;
    endfunction

    // receiver stall pattern: runs of always-ready, random, and mostly-stalled
    int rx_mode = 0;
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) rx_mode <= int'($urandom_range(0, 2));
        case (rx_mode)
            0: ang_if.ready <= 1'b1;
            1: ang_if.ready <= 1'($urandom_range(0, 1));
            default: ang_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_angles e;
        logic signed [OUT_W-1:0] got_p, got_r;
        if (i_rst_n && ang_if.valid && ang_if.ready) begin
            {got_p, got_r} = ang_if.data;
            if (angles_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d/%0d", got_p, got_r));
            end else begin
                e = angles_due.pop_front();
                if (got_p !== e.pitch)
                    report_mismatch($sformatf("pitch %0d, want %0d", got_p, e.pitch));
                if (got_r !== e.roll)
                    report_mismatch($sformatf("roll %0d, want %0d", got_r, e.roll));
            end
        end
    end

    initial begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_row dir_rows [$];
        int unsigned pscl [5] = '{1, 512, 0, 1023, 300};
        int unsigned rscl [5] = '{512, 1, 1023, 0, 77};
        // bytes x, y, z, low; typed expectation at reset scales
        dir_rows = '{
            '{8'd128, 8'd128, 8'd128, 8'h00, 1'b1, 0, 0},     // all axes zero
            '{8'd128, 8'd128, 8'd128, 8'h03, 1'b1, 0, 0},     // ignored low bits
            '{8'd255, 8'd128, 8'd128, 8'h0C, 1'b1, 64, 0},    // zero denominator, +x
            '{8'd0,   8'd128, 8'd128, 8'h00, 1'b1, -64, 0},   // zero denominator, -x
            '{8'd128, 8'd255, 8'd128, 8'h30, 1'b1, 0, 80},    // zero denominator, +y
            '{8'd128, 8'd0,   8'd128, 8'h00, 1'b1, 0, -80},
            '{8'd128, 8'd128, 8'd255, 8'hC0, 1'b1, 0, 0},     // zero numerators
            '{8'd128, 8'd128, 8'd0,   8'h00, 1'b1, 0, 0},
            '{8'd255, 8'd255, 8'd255, 8'hFF, 1'b0, 0, 0},
            '{8'd0,   8'd0,   8'd0,   8'h00, 1'b0, 0, 0},
            '{8'd255, 8'd0,   8'd255, 8'hAA, 1'b0, 0, 0},
            '{8'd0,   8'd255, 8'd0,   8'h55, 1'b0, 0, 0},
            '{8'd129, 8'd127, 8'd128, 8'h00, 1'b0, 0, 0},
            '{8'd128, 8'd128, 8'd129, 8'h00, 1'b0, 0, 0},
            '{8'd200, 8'd60,  8'd140, 8'h9C, 1'b0, 0, 0},
            '{8'd40,  8'd210, 8'd90,  8'h63, 1'b0, 0, 0}
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_report(dir_rows[k]);
            if (k % 4 == 3) sender_gap();
        end
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_scale(CFG_PITCH_SCALE, pscl[ph]);
            write_scale(CFG_ROLL_SCALE, rscl[ph]);
            for (int n = 0; n < 80; n++) begin
                send_report(rand_row());
                if ($urandom_range(0, 5) == 0) sender_gap();
            end
            drain();
        end

        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
